// ===== hdl/imhb_pkg.sv =====
// Package: sizes, types and codes shared by the indexed max-heap bank.
package imhb_pkg;
  localparam int HEAP_ROWS    = 16;
  localparam int HEAP_ENTRIES = 32;
  localparam int KEY_WIDTH    = 32;

  localparam int ROW_W   = (HEAP_ROWS > 1) ? $clog2(HEAP_ROWS) : 1;
  localparam int HEAPS   = HEAP_ROWS * 2;
  localparam int HEAP_W  = ROW_W + 1;
  localparam int SLOT_W  = $clog2(HEAP_ENTRIES);
  localparam int FILL_W  = $clog2(HEAP_ENTRIES + 1);
  localparam int ADDR_W  = HEAP_W + SLOT_W;
  localparam int WORDS   = HEAPS * HEAP_ENTRIES;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [HEAP_W-1:0] heap_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [KEY_WIDTH-1:0] key_t;

  typedef enum logic {REQ_APPEND = 1'b0, REQ_CHANGE = 1'b1} req_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MAPRD, S_MAPWT, S_WRNEW, S_RDA, S_RDB, S_RDC, S_CMP,
    S_SWAP1, S_SWAP2, S_TOPRD, S_TOPWT, S_OUT
  } fsm_t;

  // one port-set of the slot memory (key + entry)
  typedef struct packed {
    logic  we;
    addr_t addr;
    key_t  key;
    slot_t ent;
  } slot_wr_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    slot_t pos;
  } map_wr_t;

  function automatic addr_t mk_addr(heap_t h, slot_t s);
    return {h, s};
  endfunction
endpackage

// ===== hdl/imhb_if.sv =====
// Interfaces: request and result channels of the heap bank.
interface imhb_req_if;
  import imhb_pkg::*;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  heap_row;
  logic        heap_kind;
  logic [4:0]  entry_id;
  logic signed [31:0] new_key;
  modport source (output valid, req_type, heap_row, heap_kind, entry_id, new_key,
                  input ready);
  modport sink   (input valid, req_type, heap_row, heap_kind, entry_id, new_key,
                  output ready);
endinterface

interface imhb_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  top_entry;
  logic signed [31:0] top_key;
  logic [5:0]  fill_count;
  logic [1:0]  status;
  modport source (output valid, top_entry, top_key, fill_count, status, input ready);
  modport sink   (input valid, top_entry, top_key, fill_count, status, output ready);
endinterface

// ===== hdl/indexed_max_heap_bank.sv =====
// Top level: indexed max-heap bank with its sift sequencer.
//
// A request item on req selects heap (heap_row, heap_kind). An append gives
// the next entry id (the fill count) the key new_key and sifts it up; a key
// change looks the entry up through the position map, writes the key and
// sifts it up or down. Each request yields one result item on rsp with the
// heap root entry, its key, the fill count and a status code.
//
// A rejected request goes from the map read straight to the root read and
// the result. Each level a sift moves up reads the current slot and its
// parent, compares, and writes the two swapped slots; each level down reads
// the current slot and both children, compares, and writes the two swapped
// slots. A sift covers at most 5 levels at 32 entries, so the slowest
// request is a key change sinking from the root. After the result is taken
// the sequencer passes through idle before the next request is taken.
// One request is in work at a time; the slot memory (two read ports, one
// write port) and the position map set that pace.
// Reset clears the fill counters and the sequencer; the heap memories are
// not cleared and are only used below the fill count. A stalled rsp holds
// the result in its output register; req.ready stays low until it is taken.
module indexed_max_heap_bank (
  input logic clk,
  input logic rst,
  imhb_req_if.sink   req,
  imhb_rsp_if.source rsp
);
  import imhb_pkg::*;

  fsm_t state, state_next;

  // request registers
  logic     is_change;
  heap_t    heap;
  slot_t    ent_id;
  key_t     key_in;
  fill_t    fill_cur;
  status_t  stat;
  // sift walk registers
  slot_t    cur, other;
  logic     going_down;
  logic     decided;
  key_t     key_a, key_b;
  slot_t    ent_a, ent_b;

  fill_t    fill [HEAPS];

  slot_wr_t swr;
  map_wr_t  mwr;
  addr_t    rd_a, rd_b, map_rd;
  key_t     q_key_a, q_key_b;
  slot_t    q_ent_a, q_ent_b, q_pos;

  imhb_slot_mem u_slot (.clk, .wr(swr), .rd_addr_a(rd_a), .rd_addr_b(rd_b),
    .rd_key_a(q_key_a), .rd_ent_a(q_ent_a), .rd_key_b(q_key_b), .rd_ent_b(q_ent_b));
  imhb_map_mem u_map (.clk, .wr(mwr), .rd_addr(map_rd), .rd_pos(q_pos));

  heap_t req_heap;
  assign req_heap = {req.heap_row[ROW_W-1:0], req.heap_kind};
  assign req.ready = (state == S_IDLE);

  // tree index helpers, widened by one bit; the root is its own parent
  logic [SLOT_W:0] parent_w, lchild_w, rchild_w;
  assign parent_w = (cur == '0) ? '0 : (({1'b0, cur} - 1'b1) >> 1);
  assign lchild_w = {cur, 1'b1};
  assign rchild_w = lchild_w + 1'b1;
  logic has_l, has_r;
  assign has_l = ({1'b0, lchild_w} < {1'b0, fill_cur});
  assign has_r = ({1'b0, rchild_w} < {1'b0, fill_cur});

  // down-walk: left key is held in key_b, right key arrives on port b;
  // take the right child unless the left one is strictly larger
  logic take_right;
  key_t child_key;
  assign take_right = has_r && !(key_b > q_key_b);
  assign child_key  = take_right ? q_key_b : key_b;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_MAPRD;
      S_MAPRD: begin
        if (stat != ST_OK) state_next = S_TOPRD;
        else if (is_change) state_next = S_MAPWT;
        else state_next = S_WRNEW;
      end
      S_MAPWT: state_next = S_WRNEW;
      S_WRNEW: state_next = S_RDA;
      S_RDA: begin
        if (!going_down && cur == '0 && decided) state_next = S_TOPRD;
        else if (going_down && !has_l) state_next = S_TOPRD;
        else state_next = S_RDB;
      end
      S_RDB:   state_next = going_down ? S_RDC : S_CMP;
      S_RDC:   state_next = S_CMP;
      S_CMP: begin
        priority if (going_down) state_next = (key_a < child_key) ? S_SWAP1 : S_TOPRD;
        else if (key_a > q_key_b) state_next = S_SWAP1;
        else if (!decided && is_change && has_l) state_next = S_RDA;
        else state_next = S_TOPRD;
      end
      S_SWAP1: state_next = S_SWAP2;
      S_SWAP2: state_next = S_RDA;
      S_TOPRD: state_next = S_TOPWT;
      S_TOPWT: state_next = S_OUT;
      S_OUT:   if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    swr = '0;
    mwr = '0;
    rd_a = mk_addr(heap, cur);
    rd_b = mk_addr(heap, other);
    map_rd = mk_addr(heap, ent_id);
    unique case (state)
      S_IDLE: map_rd = mk_addr(req_heap, req.entry_id[SLOT_W-1:0]);
      S_MAPRD: if (stat == ST_OK && !is_change) begin
        mwr = '{we: 1'b1, addr: mk_addr(heap, fill_cur[SLOT_W-1:0]),
                pos: fill_cur[SLOT_W-1:0]};
      end
      S_RDB: begin
        rd_b = mk_addr(heap, going_down ? lchild_w[SLOT_W-1:0] : parent_w[SLOT_W-1:0]);
      end
      S_RDC: rd_b = mk_addr(heap, rchild_w[SLOT_W-1:0]);
      S_SWAP1: begin
        swr = '{we: 1'b1, addr: mk_addr(heap, cur), key: key_b, ent: ent_b};
        mwr = '{we: 1'b1, addr: mk_addr(heap, ent_b), pos: cur};
      end
      S_SWAP2: begin
        swr = '{we: 1'b1, addr: mk_addr(heap, other), key: key_a, ent: ent_a};
        mwr = '{we: 1'b1, addr: mk_addr(heap, ent_a), pos: other};
      end
      S_TOPRD: rd_a = mk_addr(heap, '0);
      default: ;
    endcase
    if (state == S_WRNEW)
      swr = '{we: 1'b1, addr: mk_addr(heap, cur), key: key_in, ent: ent_a};
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (req.valid) begin
        heap      <= req_heap;
        is_change <= req.req_type;
        ent_id    <= req.entry_id[SLOT_W-1:0];
        key_in    <= key_t'(req.new_key);
        fill_cur  <= fill[req_heap];
        decided   <= 1'b0;
        going_down <= 1'b0;
        if (req.req_type == REQ_APPEND) begin
          stat <= (fill[req_heap] >= fill_t'(HEAP_ENTRIES)) ? ST_FULL : ST_OK;
        end else begin
          stat <= ({1'b0, req.entry_id} >= 6'(fill[req_heap])) ? ST_ABSENT : ST_OK;
        end
      end
      S_MAPRD: if (stat == ST_OK && !is_change) begin
        cur     <= fill_cur[SLOT_W-1:0];
        ent_a   <= fill_cur[SLOT_W-1:0];
        decided <= 1'b1;
        fill_cur <= fill_cur + 1'b1;
      end
      S_MAPWT: begin
        cur   <= q_pos;
        ent_a <= ent_id;
      end
      S_RDB: begin
        key_a <= q_key_a;
        ent_a <= q_ent_a;
        other <= going_down ? lchild_w[SLOT_W-1:0] : parent_w[SLOT_W-1:0];
      end
      S_RDC: begin
        key_b <= q_key_b;
        ent_b <= q_ent_b;
      end
      S_CMP: begin
        if (going_down) begin
          // switch to the right child unless the left one is strictly larger
          if (take_right) begin
            key_b <= q_key_b; ent_b <= q_ent_b; other <= rchild_w[SLOT_W-1:0];
          end
        end else begin
          // capture the parent for the swap
          key_b <= q_key_b;
          ent_b <= q_ent_b;
          if (!(key_a > q_key_b)) going_down <= !decided;
        end
        decided <= 1'b1;
      end
      S_SWAP2: cur <= other;
      S_TOPWT: begin
        key_a <= q_key_a;
        ent_a <= q_ent_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < HEAPS; i++) fill[i] <= '0;
    end else begin
      state <= state_next;
      if (state == S_MAPRD && stat == ST_OK && !is_change)
        fill[heap] <= fill_cur + 1'b1;
    end
  end

  assign rsp.valid      = (state == S_OUT);
  assign rsp.top_entry  = (fill_cur == '0) ? '0 : 5'(ent_a);
  assign rsp.top_key    = (fill_cur == '0) ? '0 : 32'(key_a);
  assign rsp.fill_count = 6'(fill_cur);
  assign rsp.status     = stat;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid) else $error("ready while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
    else $error("result dropped");
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.fill_count <= 6'(HEAP_ENTRIES)) else $error("fill overflow");
`endif
endmodule

// ===== hdl/imhb_slot_mem.sv =====
// Slot memory: key and entry id per heap slot, two read ports, one write port.
module imhb_slot_mem (
  input  logic                clk,
  input  imhb_pkg::slot_wr_t  wr,
  input  imhb_pkg::addr_t     rd_addr_a,
  input  imhb_pkg::addr_t     rd_addr_b,
  output imhb_pkg::key_t      rd_key_a,
  output imhb_pkg::slot_t     rd_ent_a,
  output imhb_pkg::key_t      rd_key_b,
  output imhb_pkg::slot_t     rd_ent_b
);
  import imhb_pkg::*;
  key_t  keys [WORDS];
  slot_t ents [WORDS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      keys[wr.addr] <= wr.key;
      ents[wr.addr] <= wr.ent;
    end
    rd_key_a <= keys[rd_addr_a];
    rd_ent_a <= ents[rd_addr_a];
    rd_key_b <= keys[rd_addr_b];
    rd_ent_b <= ents[rd_addr_b];
  end
endmodule

// ===== hdl/imhb_map_mem.sv =====
// Position map memory: slot of each entry id, one write and one read port.
module imhb_map_mem (
  input  logic               clk,
  input  imhb_pkg::map_wr_t  wr,
  input  imhb_pkg::addr_t    rd_addr,
  output imhb_pkg::slot_t    rd_pos
);
  import imhb_pkg::*;
  slot_t pos [WORDS];

  always_ff @(posedge clk) begin
    if (wr.we) pos[wr.addr] <= wr.pos;
    rd_pos <= pos[rd_addr];
  end
endmodule

// ===== bench/tb_indexed_max_heap_bank.sv =====
// Testbench: indexed max-heap bank checked against a behavioral heap predictor.
module tb_indexed_max_heap_bank;
  import imhb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1750;

  typedef struct packed {
    req_t              kind_req;
    logic [3:0]        row;
    logic              kind;
    logic [4:0]        entry;
    logic signed [31:0] key;
  } heap_req_t;

  typedef struct packed {
    logic [4:0]        top_entry;
    logic signed [31:0] top_key;
    logic [5:0]        fill;
    status_t           status;
  } heap_rsp_t;

  logic clk;
  logic rst;

  imhb_req_if req_ch();
  imhb_rsp_if rsp_ch();

  indexed_max_heap_bank dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  // Predictor state: one key/entry array and position map per heap.
  logic signed [31:0] pred_key [HEAPS][HEAP_ENTRIES];
  logic [4:0]         pred_ent [HEAPS][HEAP_ENTRIES];
  logic [4:0]         pred_pos [HEAPS][HEAP_ENTRIES];
  int                 pred_fill [HEAPS];

  heap_req_t pending_reqs[$];
  heap_rsp_t expected_rsps[$];

  int  mismatches;
  int  results_seen;
  int  idle_cycles;
  int  send_wait;
  int  recv_wait;
  bit  hold_for_drain;
  int  appends_ok, changes_ok, full_hits, absent_hits;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void swap_slots(int h, int a, int b);
    logic signed [31:0] k;
    logic [4:0] e;
    k = pred_key[h][a];
    e = pred_ent[h][a];
    pred_key[h][a] = pred_key[h][b];
    pred_ent[h][a] = pred_ent[h][b];
    pred_key[h][b] = k;
    pred_ent[h][b] = e;
    pred_pos[h][pred_ent[h][a]] = a[4:0];
    pred_pos[h][pred_ent[h][b]] = b[4:0];
  endfunction

  function automatic void bubble_up(int h, int c);
    int p;
    while (c > 0) begin
      p = (c - 1) / 2;
      if (pred_key[h][c] > pred_key[h][p]) begin
        swap_slots(h, c, p);
        c = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void bubble_down(int h, int c, int n);
    int l;
    int child;
    if (n <= 1) return;
    while (c <= (n - 2) / 2) begin
      l = 2 * c + 1;
      if (l + 1 == n) child = l;
      else child = (pred_key[h][l] > pred_key[h][l + 1]) ? l : l + 1;
      if (pred_key[h][c] < pred_key[h][child]) begin
        swap_slots(h, c, child);
        c = child;
      end else begin
        break;
      end
    end
  endfunction

  // Apply one request to the predicted heap and return the result it yields.
  function automatic heap_rsp_t apply_heap_req(heap_req_t r);
    heap_rsp_t o;
    int h;
    int n;
    int c;
    int p;
    h = r.row * 2 + r.kind;
    n = pred_fill[h];
    o.status = ST_OK;
    if (r.kind_req == REQ_APPEND) begin
      if (n >= HEAP_ENTRIES) begin
        o.status = ST_FULL;
        full_hits++;
      end else begin
        pred_key[h][n] = r.key;
        pred_ent[h][n] = n[4:0];
        pred_pos[h][n] = n[4:0];
        pred_fill[h] = n + 1;
        bubble_up(h, n);
        appends_ok++;
      end
    end else begin
      if (r.entry >= n) begin
        o.status = ST_ABSENT;
        absent_hits++;
      end else begin
        c = pred_pos[h][r.entry];
        p = (c > 0) ? (c - 1) / 2 : 0;
        pred_key[h][c] = r.key;
        if (pred_key[h][c] > pred_key[h][p]) bubble_up(h, c);
        else bubble_down(h, c, n);
        changes_ok++;
      end
    end
    n = pred_fill[h];
    o.top_entry = (n > 0) ? pred_ent[h][0] : '0;
    o.top_key   = (n > 0) ? pred_key[h][0] : '0;
    o.fill      = n[5:0];
    return o;
  endfunction

  // Fill count a heap will have once every queued item has been applied.
  function automatic int pred_fill_shadow(int h);
    int n;
    n = pred_fill[h];
    foreach (pending_reqs[i])
      if (pending_reqs[i].row * 2 + pending_reqs[i].kind == h
          && pending_reqs[i].kind_req == REQ_APPEND && n < HEAP_ENTRIES)
        n++;
    return n;
  endfunction

  function automatic heap_req_t make_req(req_t t, int row, int kind, int entry,
                                         logic signed [31:0] key);
    heap_req_t r;
    r.kind_req = t;
    r.row   = row[3:0];
    r.kind  = kind[0];
    r.entry = entry[4:0];
    r.key   = key;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 7)));
      default: return $signed($urandom());
    endcase
  endfunction

  // Driver: hold each item until accepted, then wait a random gap.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_wait    <= 0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold the current item
    end else if (hold_for_drain && expected_rsps.size() != 0) begin
      req_ch.valid <= 1'b0;
    end else if (send_wait > 0) begin
      req_ch.valid <= 1'b0;
      send_wait    <= send_wait - 1;
    end else if (pending_reqs.size() != 0) begin
      heap_req_t r;
      r = pending_reqs.pop_front();
      expected_rsps.push_back(apply_heap_req(r));
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= r.kind_req;
      req_ch.heap_row  <= r.row;
      req_ch.heap_kind <= r.kind;
      req_ch.entry_id  <= r.entry;
      req_ch.new_key   <= r.key;
      send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_wait    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        heap_rsp_t want;
        results_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: entry %0d key %0d fill %0d status %0d",
                     rsp_ch.top_entry, rsp_ch.top_key, rsp_ch.fill_count,
                     rsp_ch.status);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_ch.top_entry !== want.top_entry || rsp_ch.top_key !== want.top_key
              || rsp_ch.fill_count !== want.fill || rsp_ch.status !== want.status)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: want e%0d k%0d f%0d s%0d, got e%0d k%0d f%0d s%0d",
                       results_seen, want.top_entry, want.top_key, want.fill,
                       want.status, rsp_ch.top_entry, rsp_ch.top_key,
                       rsp_ch.fill_count, rsp_ch.status);
          end
        end
        recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        rsp_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait    <= recv_wait - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int h;
    int row;
    int kind;
    int n;
    int wait_cycles;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_APPEND;
    req_ch.heap_row = '0;
    req_ch.heap_kind = 1'b0;
    req_ch.entry_id = '0;
    req_ch.new_key = '0;
    rsp_ch.ready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    hold_for_drain = 1'b0;
    appends_ok = 0; changes_ok = 0; full_hits = 0; absent_hits = 0;
    for (int i = 0; i < HEAPS; i++) pred_fill[i] = 0;

    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: change on an empty heap, extremes, ties, and the last row.
    pending_reqs.push_back(make_req(REQ_CHANGE, 0, 0, 0, 32'sd5));
    pending_reqs.push_back(make_req(REQ_APPEND, 0, 0, 31, 32'sh80000000));
    pending_reqs.push_back(make_req(REQ_APPEND, 0, 0, 0, 32'sh7fffffff));
    pending_reqs.push_back(make_req(REQ_APPEND, 0, 0, 0, 32'sd0));
    pending_reqs.push_back(make_req(REQ_APPEND, 0, 0, 0, 32'sd0));
    pending_reqs.push_back(make_req(REQ_CHANGE, 0, 0, 1, 32'sh80000000));
    pending_reqs.push_back(make_req(REQ_CHANGE, 0, 0, 2, 32'sh7fffffff));
    pending_reqs.push_back(make_req(REQ_CHANGE, 0, 0, 4, 32'sd1));
    pending_reqs.push_back(make_req(REQ_CHANGE, 0, 0, 31, 32'sd1));
    pending_reqs.push_back(make_req(REQ_APPEND, 15, 1, 0, -32'sd1));
    pending_reqs.push_back(make_req(REQ_CHANGE, 15, 1, 0, 32'sd3));
    pending_reqs.push_back(make_req(REQ_APPEND, 15, 1, 0, 32'sd3));
    // Fill heap (15,0) past capacity to hit the full case.
    for (int i = 0; i < HEAP_ENTRIES + 2; i++)
      pending_reqs.push_back(make_req(REQ_APPEND, 15, 0, 0, rand_key()));
    pending_reqs.push_back(make_req(REQ_CHANGE, 15, 0, 31, 32'sh80000000));

    // Random: mostly changes of present entries, appends, and a little noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      row  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      kind = $urandom_range(0, 1);
      h = row * 2 + kind;
      n = pred_fill_shadow(h);
      if (i == RANDOM_ITEMS / 2) begin
        // wait for the queue to drain, then block the driver until idle
        while (pending_reqs.size() != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        hold_for_drain <= 1'b1;
        while ((expected_rsps.size() != 0 || req_ch.valid)
               && idle_cycles < WATCHDOG_LIMIT)
          @(posedge clk);
        hold_for_drain <= 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: pending_reqs.push_back(make_req(REQ_APPEND, row, kind,
                                                 $urandom_range(0, 31), rand_key()));
        9: pending_reqs.push_back(make_req(REQ_CHANGE, row, kind,
                                           $urandom_range(0, 31), rand_key()));
        default: pending_reqs.push_back(make_req(REQ_CHANGE, row, kind,
            (n > 0) ? $urandom_range(0, n - 1) : 0, rand_key()));
      endcase
    end

    while ((pending_reqs.size() != 0 || expected_rsps.size() != 0)
           && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 40 && idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d results still due", expected_rsps.size());
      $display("tb_indexed_max_heap_bank: errors");
    end else begin
      $display("covered %0d results: %0d appends, %0d key changes, %0d full, %0d absent",
               results_seen, appends_ok, changes_ok, full_hits, absent_hits);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0)
        $display("tb_indexed_max_heap_bank: clean");
      else
        $display("tb_indexed_max_heap_bank: errors");
    end
    $finish;
  end

endmodule
